/* design/lcdw_pkg.sv */
// shared types, constants and helpers for the character lcd text writer
package lcdw_pkg;

    localparam int unsigned ROW_COUNT_DEF = 4;

    localparam logic [15:0] STROBE_US_RST  = 16'd100;
    localparam logic [15:0] CMD_WAIT_RST   = 16'd2000;
    localparam logic [15:0] DATA_WAIT_RST  = 16'd100;
    localparam logic [4:0]  ROW_LEN_RST    = 5'd20;
    localparam logic [4:0]  ROW_LEN_MAX    = 5'd20;
    localparam logic [7:0]  SET_ADDR_CMD   = 8'b1000_0000;

    localparam logic [1:0] REG_STROBE_US = 2'd0;
    localparam logic [1:0] REG_CMD_WAIT  = 2'd1;
    localparam logic [1:0] REG_DATA_WAIT = 2'd2;
    localparam logic [1:0] REG_ROW_LEN   = 2'd3;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TEXT   = 2'd0,
        FUNC_CMD    = 2'd1,
        FUNC_CURSOR = 2'd2
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [7:0]  code;
        logic        end_of_message;
        logic [4:0]  col;
        logic [1:0]  row;
    } t_in_item;

    typedef struct packed {
        logic        rs_level;
        logic [3:0]  nibble;
        logic [15:0] settle_us;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [15:0] cmd_wait_us;
        logic [15:0] data_wait_us;
        logic [4:0]  row_length;
    } t_cfg;

    // up to two bytes per item; the second slot is always sent, the first
    // (set-address command) only when two is set
    typedef struct packed {
        logic        two;
        logic [7:0]  b0_val;
        logic [15:0] b0_wait;
        logic        b1_rs;
        logic [7:0]  b1_val;
        logic [15:0] b1_wait;
    } t_burst;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        unique case (row)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h14;
            default: off = 8'h54;
        endcase
        return off;
    endfunction

endpackage

/* design/lcdw_cursor.sv */
// cursor state and per-item decode into a burst of up to two bytes
module lcdw_cursor #(
    parameter int unsigned ROW_COUNT = lcdw_pkg::ROW_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  lcdw_pkg::t_in_item i_item,
    input  lcdw_pkg::t_cfg    i_cfg,
    output logic              o_has,
    output lcdw_pkg::t_burst  o_burst
);

    localparam logic [2:0] ROW_CNT = 3'(ROW_COUNT);

    logic [4:0] r_col, n_col;
    logic [2:0] r_row, n_row;
    logic       r_pend, n_pend;

    logic [4:0] len;
    logic [4:0] col_w;
    logic [2:0] row_w;
    logic       pend_w;
    logic [4:0] col_nx;

    always_comb begin
        if (i_cfg.row_length == 5'd0) begin
            len = 5'd1;
        end else if (i_cfg.row_length > lcdw_pkg::ROW_LEN_MAX) begin
            len = lcdw_pkg::ROW_LEN_MAX;
        end else begin
            len = i_cfg.row_length;
        end
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_pend  = r_pend;
        col_w   = r_col;
        row_w   = r_row;
        pend_w  = r_pend;
        col_nx  = 5'd0;
        o_has   = 1'b0;
        o_burst = '0;
        unique case (i_item.func)
            lcdw_pkg::FUNC_CMD: begin
                o_has           = 1'b1;
                o_burst.b1_rs   = lcdw_pkg::RS_CMD;
                o_burst.b1_val  = i_item.code;
                o_burst.b1_wait = i_cfg.cmd_wait_us;
            end
            lcdw_pkg::FUNC_CURSOR: begin
                n_col  = i_item.col;
                n_row  = {1'b0, i_item.row};
                n_pend = 1'b1;
            end
            lcdw_pkg::FUNC_TEXT: begin
                // wrap a column left past the row end
                if (r_col >= len) begin
                    col_w  = 5'd0;
                    row_w  = (r_row < ROW_CNT) ? r_row + 3'd1 : r_row;
                    pend_w = 1'b1;
                end
                n_col  = col_w;
                n_row  = row_w;
                n_pend = pend_w;
                if (row_w < ROW_CNT) begin
                    o_has           = 1'b1;
                    o_burst.two     = pend_w;
                    o_burst.b0_val  = lcdw_pkg::SET_ADDR_CMD
                                    + lcdw_pkg::row_offset(row_w[1:0])
                                    + {3'b000, col_w};
                    o_burst.b0_wait = i_cfg.cmd_wait_us;
                    o_burst.b1_rs   = lcdw_pkg::RS_DATA;
                    o_burst.b1_val  = i_item.code;
                    o_burst.b1_wait = i_cfg.data_wait_us;
                    col_nx          = col_w + 5'd1;
                    if (col_nx >= len || i_item.end_of_message) begin
                        n_col  = 5'd0;
                        n_row  = row_w + 3'd1;
                        n_pend = 1'b1;
                    end else begin
                        n_col  = col_nx;
                        n_pend = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 5'd0;
            r_row  <= 3'd0;
            r_pend <= 1'b1;
        end else if (i_take) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
        end
    end

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_CNT)
        else $error("cursor row beyond row count");

endmodule

/* design/lcdw_nibble_out.sv */
// output stage: sends a burst as nibbles, high nibble first
module lcdw_nibble_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  lcdw_pkg::t_burst   i_burst,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lcdw_pkg::t_out_item o_out_item
);

    localparam logic [1:0] FIRST_IDX_TWO = 2'd0;
    localparam logic [1:0] FIRST_IDX_ONE = 2'd2;
    localparam logic [1:0] LAST_IDX      = 2'd3;

    logic             r_valid;
    logic [1:0]       r_idx;
    lcdw_pkg::t_burst r_burst;

    logic       done;
    logic       sel_rs;
    logic [7:0] sel_val;
    logic [15:0] sel_wait;

    assign done   = r_valid && i_out_ready && (r_idx == LAST_IDX);
    assign o_free = !r_valid || done;

    always_comb begin
        if (r_idx[1]) begin
            sel_rs   = r_burst.b1_rs;
            sel_val  = r_burst.b1_val;
            sel_wait = r_burst.b1_wait;
        end else begin
            sel_rs   = lcdw_pkg::RS_CMD;
            sel_val  = r_burst.b0_val;
            sel_wait = r_burst.b0_wait;
        end
        o_out_item.rs_level    = sel_rs;
        o_out_item.nibble      = r_idx[0] ? sel_val[3:0] : sel_val[7:4];
        o_out_item.settle_us   = r_idx[0] ? sel_wait : 16'd0;
        o_out_item.last_of_run = (r_idx == LAST_IDX);
    end

    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_burst <= i_burst;
            r_idx   <= i_burst.two ? FIRST_IDX_TWO : FIRST_IDX_ONE;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_out_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    a_settle_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_idx[0] |-> o_out_item.settle_us == 16'd0)
        else $error("settle time on a first nibble");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done && !i_load |=> !r_valid)
        else $error("output stage did not empty after last nibble");

endmodule

/* design/char_lcd_text_writer_4bit_core.sv */
// top level of the character lcd text writer on a 4-bit bus
// path: with the output stage free, an accepted item is registered in the burst
//   stage and then loaded into the output stage, which offers the first nibble
// throughput: an item with a set-address command sends four nibbles, a plain
//   character or raw command two, a cursor placement none; the nibble output
//   (one nibble per cycle while i_out_ready is high) sets the rate
// reset: synchronous active low; cursor at row 0 column 0 with a row start
//   pending, registers at their defaults, no item in flight
module char_lcd_text_writer_4bit_core #(
    parameter int unsigned ROW_COUNT = lcdw_pkg::ROW_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item in
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lcdw_pkg::t_in_item  i_in_item,
    // nibble out
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcdw_pkg::t_out_item o_out_item,
    // register writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    // config registers; the enable pulse width is timed by the bus driver
    // downstream, so its register index is accepted but nothing keeps it
    lcdw_pkg::t_cfg r_cfg;

    // burst stage between decode and the nibble output stage
    logic             r_a_valid;
    lcdw_pkg::t_burst r_a;

    logic             in_take;
    logic             dec_has;
    lcdw_pkg::t_burst dec_burst;
    logic             out_free;
    logic             a_to_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_wait_us  <= lcdw_pkg::CMD_WAIT_RST;
            r_cfg.data_wait_us <= lcdw_pkg::DATA_WAIT_RST;
            r_cfg.row_length   <= lcdw_pkg::ROW_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lcdw_pkg::REG_CMD_WAIT:  r_cfg.cmd_wait_us  <= i_cfg_data;
                lcdw_pkg::REG_DATA_WAIT: r_cfg.data_wait_us <= i_cfg_data;
                lcdw_pkg::REG_ROW_LEN:   r_cfg.row_length   <= i_cfg_data[4:0];
                default: begin
                    // strobe width write: no effect on the nibble stream
                end
            endcase
        end
    end

    // the burst stage drains into the output stage whenever that one is
    // empty or hands off its last nibble, so a new item can enter while
    // an earlier one is still being sent
    assign a_to_b     = r_a_valid && out_free;
    assign o_in_ready = !r_a_valid || a_to_b;
    assign in_take    = i_in_valid && o_in_ready;

    lcdw_cursor #(
        .ROW_COUNT (ROW_COUNT)
    ) u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_has   (dec_has),
        .o_burst (dec_burst)
    );

    // items with no nibbles (cursor placement, dropped text) only move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            if (in_take && dec_has) begin
                r_a_valid <= 1'b1;
                r_a       <= dec_burst;
            end else if (a_to_b) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    lcdw_nibble_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (a_to_b),
        .i_burst     (r_a),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_burst_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_to_b |=> r_a_valid && $stable(r_a))
        else $error("pending burst lost or changed before hand-off");

endmodule
